FILE: hw/rtl/mpbt_pkg.sv
// ----------------------------------------------------------------------------
// mpbt_pkg
// Shared types, constants and helpers for the memory pressure budget throttle.
// ----------------------------------------------------------------------------
package mpbt_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CntW   = 2;
	localparam int unsigned CfgIdxW = 3;

	// Beat widths: fields packed from bit 0, padded to whole bytes.
	localparam int unsigned InDataRawW  = 4 * WordW + 1 + ByteW;     // 137
	localparam int unsigned InDataW     = ((InDataRawW + 7) / 8) * 8;
	localparam int unsigned OutDataRawW = ByteW + 1 + 2 * WordW;     // 73
	localparam int unsigned OutDataW    = ((OutDataRawW + 7) / 8) * 8;

	// Reset values of the configuration registers.
	localparam logic [WordW-1:0] RstStartLimitA = 32'hFFFF_FFFF;
	localparam logic [WordW-1:0] RstStartLimitB = 32'hFFFF_FFFF;
	localparam logic [WordW-1:0] RstMinInterval = 32'h0000_0040;
	localparam logic [WordW-1:0] RstStaleIntvl  = 32'h0000_0100;
	localparam logic [WordW-1:0] RstFreeFloor   = 32'h0002_0000;

	localparam logic [CntW-1:0] CntMax = 2'd3;
	localparam logic [CntW-1:0] CntHalveAt = 2'd2;

	typedef enum logic [CfgIdxW-1:0] {
		REG_START_LIMIT_A = 3'd0,
		REG_START_LIMIT_B = 3'd1,
		REG_MIN_INTERVAL  = 3'd2,
		REG_STALE_INTERVAL = 3'd3,
		REG_FREE_FLOOR    = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		ACT_CHECK  = 1'b0,
		ACT_RELOAD = 1'b1
	} action_t;

	typedef struct packed {
		logic [ByteW-1:0] evict_status;
		logic [WordW-1:0] free_mem;
		logic [WordW-1:0] total_mem;
		logic             active;
		logic [WordW-1:0] request_size;
		logic [WordW-1:0] tick;
	} check_item_t;

	typedef struct packed {
		logic [WordW-1:0] limit_b_now;
		logic [WordW-1:0] limit_a_now;
		logic             evict;
		logic [ByteW-1:0] result_byte;
	} check_result_t;

	typedef struct packed {
		logic [CntW-1:0]  cnt;
		logic [WordW-1:0] lim;
	} miss_state_t;

	// Advance a miss counter; a quick repeat halves the limit (floor of 1).
	function automatic miss_state_t bump_miss(input miss_state_t cur, input logic stale);
		miss_state_t      res;
		logic [CntW-1:0]  nxt;
		res = cur;
		nxt = (cur.cnt < CntMax) ? cur.cnt + 1'b1 : CntMax;
		if (stale) begin
			res.cnt = {{(CntW-1){1'b0}}, 1'b1};
		end else if (nxt >= CntHalveAt && cur.lim >= 32'd2) begin
			res.cnt = '0;
			res.lim = cur.lim >> 1;
		end else begin
			res.cnt = nxt;
		end
		return res;
	endfunction

endpackage

FILE: hw/rtl/memory_pressure_budget_throttle.sv
// ----------------------------------------------------------------------------
// memory_pressure_budget_throttle
// Decides per check beat whether to evict managed memory, adapting two limits.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+------------------------------------------
//  s       | in  | s_tvalid/s_tready  | check beat: tick, request, active, mem, status
//  m       | out | m_tvalid/m_tready  | result beat: byte, evict, limit A, limit B
//  cfg     | in  | cfg_valid/cfg_ready| register write: cfg_index, cfg_data
//
//  One beat per cycle sustained while m_tready stays high. A beat is captured
//  into the _s1 input register, evaluated against the limit/counter state and
//  lands in the output register; state is written on that same edge, so the
//  next beat sees it. m_tvalid rises when the beat moves from the _s1 register
//  into the output register, which a stall on m can hold off.
//  arst_n clears state and counters, sets limits to all ones and loads the
//  config registers with their defaults.
//  A stall on m holds the output register and the input register; s_tready
//  drops only when both are full and m_tready is low. cfg_ready is always high.
//
module memory_pressure_budget_throttle
	import mpbt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// check beats
	input  logic                s_tvalid,
	output logic                s_tready,
	// [31:0] tick, [63:32] request_size, [64] active, [96:65] total_mem,
	// [128:97] free_mem, [136:129] evict_status, upper bits zero
	input  logic [InDataW-1:0]  s_tdata,
	// [0] action
	input  logic                s_tuser,
	// result beats
	output logic                m_tvalid,
	input  logic                m_tready,
	// [7:0] result_byte, [8] evict, [40:9] limit_a_now, [72:41] limit_b_now,
	// upper bits zero
	output logic [OutDataW-1:0] m_tdata,
	// register writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [WordW-1:0]    cfg_data
);

	// configuration registers
	logic [WordW-1:0] start_limit_a_q, start_limit_b_q;
	logic [WordW-1:0] min_interval_q, stale_interval_q, free_floor_q;

	// block state
	logic [WordW-1:0] last_evict_tick_q;
	logic [CntW-1:0]  miss_count_a_q, miss_count_b_q;
	logic [WordW-1:0] limit_a_q, limit_b_q;

	// input stage
	logic        valid_s1;
	check_item_t item_s1;
	action_t     action_s1;

	// output register
	logic          out_valid_q;
	check_result_t out_q;

	logic advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(OutDataW-OutDataRawW){1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_limit_a_q  <= RstStartLimitA;
			start_limit_b_q  <= RstStartLimitB;
			min_interval_q   <= RstMinInterval;
			stale_interval_q <= RstStaleIntvl;
			free_floor_q     <= RstFreeFloor;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_LIMIT_A:  start_limit_a_q  <= cfg_data;
				REG_START_LIMIT_B:  start_limit_b_q  <= cfg_data;
				REG_MIN_INTERVAL:   min_interval_q   <= cfg_data;
				REG_STALE_INTERVAL: stale_interval_q <= cfg_data;
				REG_FREE_FLOOR:     free_floor_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1   <= check_item_t'(s_tdata[InDataRawW-1:0]);
			action_s1 <= action_t'(s_tuser);
		end
	end

	// ---- evaluation ----
	logic [WordW-1:0] elapsed;
	logic             too_soon, below_a, evict_hit, stale;
	miss_state_t      bump_a, bump_b;
	logic [WordW-1:0] nxt_limit_a, nxt_limit_b, nxt_last_tick;
	logic [CntW-1:0]  nxt_cnt_a, nxt_cnt_b;
	logic [ByteW-1:0] nxt_byte;
	logic             nxt_evict;

	assign elapsed   = item_s1.tick - last_evict_tick_q;
	assign too_soon  = elapsed < min_interval_q;
	assign below_a   = item_s1.total_mem < limit_a_q;
	assign evict_hit = below_a
		|| (item_s1.free_mem < free_floor_q && item_s1.request_size < limit_b_q);
	assign stale     = elapsed > stale_interval_q;
	// total under limit A: counter B steers limit A; else counter A steers B
	assign bump_a    = bump_miss('{cnt: miss_count_b_q, lim: limit_a_q}, stale);
	assign bump_b    = bump_miss('{cnt: miss_count_a_q, lim: limit_b_q}, stale);

	always_comb begin
		nxt_limit_a   = limit_a_q;
		nxt_limit_b   = limit_b_q;
		nxt_cnt_a     = miss_count_a_q;
		nxt_cnt_b     = miss_count_b_q;
		nxt_last_tick = last_evict_tick_q;
		nxt_byte      = '0;
		nxt_evict     = 1'b0;
		if (action_s1 == ACT_RELOAD) begin
			nxt_limit_a = start_limit_a_q;
			nxt_limit_b = start_limit_b_q;
			nxt_cnt_a   = '0;
			nxt_cnt_b   = '0;
		end else if (!item_s1.active) begin
			nxt_byte = item_s1.tick[ByteW-1:0];
		end else if (too_soon) begin
			nxt_byte = elapsed[ByteW-1:0];
		end else if (evict_hit) begin
			if (below_a) begin
				nxt_cnt_a   = '0;
				nxt_cnt_b   = bump_a.cnt;
				nxt_limit_a = bump_a.lim;
			end else begin
				nxt_cnt_b   = '0;
				nxt_cnt_a   = bump_b.cnt;
				nxt_limit_b = bump_b.lim;
			end
			nxt_last_tick = item_s1.tick;
			nxt_byte      = item_s1.evict_status;
			nxt_evict     = 1'b1;
		end else begin
			nxt_byte = item_s1.free_mem[ByteW-1:0];
		end
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_evict_tick_q <= '0;
			miss_count_a_q    <= '0;
			miss_count_b_q    <= '0;
			limit_a_q         <= '1;
			limit_b_q         <= '1;
			out_valid_q       <= 1'b0;
		end else begin
			if (advance) begin
				last_evict_tick_q <= nxt_last_tick;
				miss_count_a_q    <= nxt_cnt_a;
				miss_count_b_q    <= nxt_cnt_b;
				limit_a_q         <= nxt_limit_a;
				limit_b_q         <= nxt_limit_b;
				out_valid_q       <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.result_byte <= nxt_byte;
			out_q.evict       <= nxt_evict;
			out_q.limit_a_now <= nxt_limit_a;
			out_q.limit_b_now <= nxt_limit_b;
		end
	end

endmodule

FILE: bench/tb_memory_pressure_budget_throttle.sv
// ----------------------------------------------------------------------------
// tb_memory_pressure_budget_throttle
// Self-checking bench: drives check and reload beats with random idle and
// backpressure, predicts every result beat from a local model of the eviction
// decision, limits and miss counters, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_memory_pressure_budget_throttle;
	import mpbt_pkg::*;

	// cycles without any handshake on s, m or cfg before the run is stopped as failed
	localparam int unsigned StuckLimit = 1000;
	localparam int unsigned RandomBeatsPerPhase = 225;
	localparam int unsigned NumPhases = 6;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                s_tuser = ACT_CHECK;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [WordW-1:0]    cfg_data = '0;

	memory_pressure_budget_throttle dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Local copy of the throttle: config registers and decision state.
	// Updated at the edge a beat is accepted, so stimulus generated after
	// a send sees the state the block will use for the next beat.
	// ------------------------------------------------------------------
	logic [WordW-1:0] cfg_start_a   = RstStartLimitA;
	logic [WordW-1:0] cfg_start_b   = RstStartLimitB;
	logic [WordW-1:0] cfg_min_gap   = RstMinInterval;
	logic [WordW-1:0] cfg_stale_gap = RstStaleIntvl;
	logic [WordW-1:0] cfg_floor     = RstFreeFloor;

	logic [WordW-1:0] evict_mark  = '0;   // tick of the last eviction
	logic [CntW-1:0]  miss_a      = '0;   // cleared on limit A evictions
	logic [CntW-1:0]  miss_b      = '0;   // cleared on limit B evictions
	logic [WordW-1:0] cur_limit_a = '1;
	logic [WordW-1:0] cur_limit_b = '1;

	check_result_t expected_decisions[$];
	int unsigned   mismatch_count = 0;
	int unsigned   stuck_cycles = 0;
	bit            idle_on = 1'b1;

	// Saturating miss counter; a quick repeat halves the paired limit unless
	// it is already down to 1 (or 0 after a zero reload).
	function automatic void advance_miss(inout logic [CntW-1:0] cnt,
			inout logic [WordW-1:0] lim, input logic stale);
		logic [CntW-1:0] bumped;
		bumped = (cnt == CntMax) ? CntMax : cnt + 1'b1;
		if (stale) begin
			cnt = CntW'(1);
		end else if (bumped >= CntHalveAt && lim >= 2) begin
			cnt = '0;
			lim = lim >> 1;
		end else begin
			cnt = bumped;
		end
	endfunction

	function automatic check_result_t decide_eviction(input action_t act,
			input check_item_t it);
		check_result_t    r;
		logic [WordW-1:0] elapsed;
		logic             low_total;
		logic             stale;
		r = '0;
		if (act == ACT_RELOAD) begin
			// reload keeps the eviction tick, result byte stays zero
			cur_limit_a = cfg_start_a;
			cur_limit_b = cfg_start_b;
			miss_a = '0;
			miss_b = '0;
		end else if (!it.active) begin
			r.result_byte = it.tick[7:0];
		end else begin
			elapsed = it.tick - evict_mark;   // wraps mod 2^32
			if (elapsed < cfg_min_gap) begin
				r.result_byte = elapsed[7:0];
			end else begin
				low_total = it.total_mem < cur_limit_a;
				if (low_total || (it.free_mem < cfg_floor && it.request_size < cur_limit_b)) begin
					stale = elapsed > cfg_stale_gap;
					// note the cross pairing: counter B drives limit A and vice versa
					if (low_total) begin
						miss_a = '0;
						advance_miss(miss_b, cur_limit_a, stale);
					end else begin
						miss_b = '0;
						advance_miss(miss_a, cur_limit_b, stale);
					end
					evict_mark = it.tick;
					r.result_byte = it.evict_status;
					r.evict = 1'b1;
				end else begin
					r.result_byte = it.free_mem[7:0];
				end
			end
		end
		r.limit_a_now = cur_limit_a;
		r.limit_b_now = cur_limit_b;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Drivers: inputs move on the falling edge, handshakes are sampled on
	// the rising edge.
	// ------------------------------------------------------------------
	task automatic send_beat(input action_t act, input check_item_t it);
		int unsigned gap;
		gap = 0;
		// each cycle idles with about one chance in four
		while (idle_on && $urandom_range(0, 99) < 24)
			gap++;
		if (gap != 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= InDataW'(it);
		do @(posedge clk); while (!s_tready);
		expected_decisions.push_back(decide_eviction(act, it));
	endtask

	task automatic check_beat(input logic [WordW-1:0] tick, input logic [WordW-1:0] req,
			input logic act_bit, input logic [WordW-1:0] total,
			input logic [WordW-1:0] free, input logic [ByteW-1:0] status);
		check_item_t it;
		it.tick = tick;
		it.request_size = req;
		it.active = act_bit;
		it.total_mem = total;
		it.free_mem = free;
		it.evict_status = status;
		send_beat(ACT_CHECK, it);
	endtask

	// reload beats carry random payload, which the block must ignore
	task automatic reload_beat();
		check_item_t it;
		it = check_item_t'(InDataRawW'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom}));
		send_beat(ACT_RELOAD, it);
	endtask

	// drop valid and wait until every predicted result has come back
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_decisions.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [WordW-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_START_LIMIT_A:  cfg_start_a = value;
			REG_START_LIMIT_B:  cfg_start_b = value;
			REG_MIN_INTERVAL:   cfg_min_gap = value;
			REG_STALE_INTERVAL: cfg_stale_gap = value;
			REG_FREE_FLOOR:     cfg_floor = value;
			default: ;
		endcase
	endtask

	// all five registers, only with the pipe empty
	task automatic load_config(input logic [WordW-1:0] start_a, input logic [WordW-1:0] start_b,
			input logic [WordW-1:0] min_gap, input logic [WordW-1:0] stale_gap,
			input logic [WordW-1:0] floor_val);
		settle();
		cfg_write(REG_START_LIMIT_A, start_a);
		cfg_write(REG_START_LIMIT_B, start_b);
		cfg_write(REG_MIN_INTERVAL, min_gap);
		cfg_write(REG_STALE_INTERVAL, stale_gap);
		cfg_write(REG_FREE_FLOOR, floor_val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Random content helpers. Values cluster around the thresholds so that
	// both sides of every compare are hit, with some fully random words.
	// ------------------------------------------------------------------
	function automatic logic [WordW-1:0] around(input logic [WordW-1:0] base);
		case ($urandom_range(0, 3))
			0: return base - $urandom_range(1, 3);
			1: return base + $urandom_range(0, 2);
			2: return base >> $urandom_range(1, 31);
			default: return $urandom;
		endcase
	endfunction

	// ticks since the last eviction: too soon, exactly on, fresh, stale
	function automatic logic [WordW-1:0] pick_elapsed();
		case ($urandom_range(0, 9))
			0, 1, 2: return (cfg_min_gap == 0) ? '0 : $urandom_range(0, cfg_min_gap - 1);
			3: return cfg_min_gap;
			4, 5, 6: return (cfg_stale_gap > cfg_min_gap) ?
				$urandom_range(cfg_min_gap, cfg_stale_gap) : cfg_min_gap;
			7: return cfg_stale_gap;
			8: return cfg_stale_gap + $urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_beat();
		logic [WordW-1:0] total;
		logic [WordW-1:0] free;
		logic [WordW-1:0] req;
		if ($urandom_range(0, 99) < 4) begin
			reload_beat();
		end else begin
			total = around(cur_limit_a);
			free  = around(cfg_floor);
			req   = around(cur_limit_b);
			check_beat(evict_mark + pick_elapsed(), req, $urandom_range(0, 99) < 90,
				total, free, ByteW'($urandom_range(0, 255)));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset configuration: inactive, too soon, both eviction paths, tick wrap,
	// halving of limit A, reload, boundaries of the floor and limit B
	task automatic test_defaults();
		check_beat(32'hA5A5_5A5F, $urandom, 1'b0, $urandom, $urandom,
			ByteW'($urandom_range(0, 255)));
		check_beat(32'd10, 32'd0, 1'b1, 32'd0, 32'd0, 8'h11);
		// limit B path, stale
		check_beat(32'hFFFF_FFFF, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'h0001_FFFF, 8'h3C);
		// tick wraps past zero, limit A path
		check_beat(32'd69, 32'hFFFF_FFFF, 1'b1, 32'd0, 32'hFFFF_FFFF, 8'hC3);
		// quick repeat halves limit A
		check_beat(32'd169, 32'd5, 1'b1, 32'd5, 32'd7, 8'hFF);
		check_beat(32'd469, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
		reload_beat();
		// free exactly at the floor: no eviction
		check_beat(32'd1000, 32'd0, 1'b1, 32'hFFFF_FFFF, RstFreeFloor, 8'h5A);
		// request at limit B: no eviction
		check_beat(32'd1000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'd0, 8'hA5);
		// elapsed exactly min interval
		check_beat(evict_mark + RstMinInterval, 32'd1, 1'b1, 32'hFFFF_FFFE, 32'd1, 8'h81);
	endtask

	// limits reloaded at 2 and 1: halving stops at 1, counters saturate
	task automatic test_limit_floor();
		int i;
		load_config(32'd2, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'd16);
		reload_beat();
		for (i = 0; i < 6; i++)
			check_beat(evict_mark + 1, $urandom, 1'b1, 32'd0, $urandom,
				ByteW'($urandom_range(0, 255)));
		for (i = 0; i < 3; i++)
			check_beat(evict_mark + 1, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'd0,
				ByteW'($urandom_range(0, 255)));
	endtask

	// zero start limits never evict; zero min interval never skips
	task automatic test_zero_limits();
		load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
		reload_beat();
		check_beat(evict_mark, 32'd0, 1'b1, 32'd0, 32'd0, 8'h77);
		check_beat(evict_mark + 32'h8000_0000, 32'd0, 1'b1, 32'd0, 32'h1234_5678, 8'h66);
	endtask

	task automatic test_random();
		int unsigned ph;
		int unsigned n;
		for (ph = 0; ph < NumPhases; ph++) begin
			idle_on = 1'b1;
			case (ph)
				0: load_config($urandom, $urandom, $urandom_range(0, 100),
					$urandom_range(0, 400), $urandom);
				1: load_config('1, '1, '0, '0, '1);
				2: begin
					// long stretch at full rate on both sides
					idle_on = 1'b0;
					load_config($urandom_range(1, 3), $urandom_range(0, 3),
						$urandom_range(0, 20), '1, $urandom);
				end
				3: load_config($urandom, $urandom, '1, '1, $urandom);
				4: load_config($urandom, $urandom, $urandom, $urandom, $urandom);
				default: load_config(32'd1, 32'd2, $urandom_range(0, 16),
					$urandom_range(0, 32), $urandom);
			endcase
			reload_beat();
			for (n = 0; n < RandomBeatsPerPhase; n++) begin
				// sender holds off until the pipe has fully drained
				if (ph == 3 && n == RandomBeatsPerPhase / 2)
					settle();
				random_beat();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random backpressure, in-order compare, watchdog
	// ------------------------------------------------------------------
	always @(negedge clk)
		m_tready <= idle_on ? ($urandom_range(0, 99) >= 24) : 1'b1;

	always @(posedge clk) begin
		check_result_t got;
		check_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = check_result_t'(m_tdata[OutDataRawW-1:0]);
			if (expected_decisions.size() == 0) begin
				$display("%0t: result beat with none expected, got %h", $time, got);
				mismatch_count++;
			end else begin
				want = expected_decisions.pop_front();
				if (got.result_byte !== want.result_byte) begin
					$display("%0t: result_byte expected %h got %h", $time,
						want.result_byte, got.result_byte);
					mismatch_count++;
				end
				if (got.evict !== want.evict) begin
					$display("%0t: evict expected %b got %b", $time, want.evict, got.evict);
					mismatch_count++;
				end
				if (got.limit_a_now !== want.limit_a_now) begin
					$display("%0t: limit_a_now expected %h got %h", $time,
						want.limit_a_now, got.limit_a_now);
					mismatch_count++;
				end
				if (got.limit_b_now !== want.limit_b_now) begin
					$display("%0t: limit_b_now expected %h got %h", $time,
						want.limit_b_now, got.limit_b_now);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == StuckLimit) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_defaults();
		test_limit_floor();
		test_zero_limits();
		test_random();
		settle();
		// _s1 and output registers: the spare edges below catch any stray result beat
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
